@@ rtl/core/sr64_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sr64_pkg
// Shared types, constants and helpers for the radix-64 text codec.
// ----------------------------------------------------------------------------
package sr64_pkg;

	localparam logic [7:0]  HDR_B0    = 8'h57;
	localparam logic [7:0]  HDR_B1    = 8'hEC;
	localparam logic [7:0]  HDR_B2    = 8'hFF;
	localparam logic [7:0]  DIGIT_OFS = 8'h30;
	localparam logic [7:0]  SCR_MASK  = 8'h50;
	localparam logic [5:0]  DIGIT_MSK = 6'h3F;

	localparam logic [1:0]  STAT_OK     = 2'd0;
	localparam logic [1:0]  STAT_SHORT  = 2'd1;
	localparam logic [1:0]  STAT_PREFIX = 2'd2;
	localparam logic [1:0]  STAT_LEN    = 2'd3;

	localparam logic [1:0]  REG_MODE = 2'd0;
	localparam logic [1:0]  REG_SCR  = 2'd1;
	localparam logic [1:0]  REG_LEN  = 2'd2;

	localparam logic [24:0] COUNT_MAX   = 25'h1FF_FFFF;
	localparam logic [24:0] MIN_CHARS   = 25'd12;
	localparam logic [24:0] HDR_CHARS   = 25'd8;
	localparam logic [24:0] PREFIX_LEN  = 25'd4;

	typedef struct packed {
		logic        hdr;
		logic [23:0] hdr_len;
		logic        grp;
		logic        grp_last;
		logic [23:0] bytes;
		logic [1:0]  nbytes;
		logic        stat;
		logic [1:0]  stat_val;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_HDR,
		BK_GRP,
		BK_RAW,
		BK_STAT
	} bk_state_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d);
		return {2'b00, d} + DIGIT_OFS;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h45;
			2'd1: c = 8'h6E;
			2'd2: c = 8'h63;
			default: c = 8'h6F;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/scrambled_radix64_text_codec.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scrambled_radix64_text_codec
// Radix-64 text codec with byte scrambler and length header; APB registers.
// ----------------------------------------------------------------------------
// The front part takes one input word per cycle while the two-entry job queue
// has room; the back part sends one output word per cycle while the output
// port takes them, and loads each job in its idle state first. Encoding: a
// three-byte group gives four characters, the first byte of a message adds
// the eight header characters. Decoding: four characters in, up to three
// bytes out per group; the last character of a message adds a closing status
// word. The output port paces the block. Registers: mode at 0x0 (writing
// it restarts the message), scramble_enable at 0x4, message_length at 0x8;
// write them only while idle.
module scrambled_radix64_text_codec (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  wire logic         push,
	output logic              full,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_in,
	output logic              empty,
	input  wire logic         pop,
	output logic [7:0]        out_byte,
	output logic              last_out,
	output logic [1:0]        status
);
	import sr64_pkg::*;

	logic        mode_q;
	logic        scr_q;
	logic [23:0] len_q;
	logic        wr;
	logic [1:0]  reg_idx;
	logic        clear;
	logic        accept;
	job_t        fr_job;
	job_t        head_job;
	logic        job_push;
	logic        job_pop;
	logic        q_empty;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr      = psel && penable && pwrite;
	assign clear   = wr && (reg_idx == REG_MODE);
	assign accept  = push && !full;

	always_comb begin
		case (reg_idx)
			REG_MODE: prdata = {31'd0, mode_q};
			REG_SCR:  prdata = {31'd0, scr_q};
			REG_LEN:  prdata = {8'd0, len_q};
			default:  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			scr_q  <= 1'b1;
			len_q  <= 24'd1;
		end else if (wr) begin
			case (reg_idx)
				REG_MODE: mode_q <= pwdata[0];
				REG_SCR:  scr_q  <= pwdata[0];
				REG_LEN:  len_q  <= pwdata[23:0];
				default:  mode_q <= mode_q;
			endcase
		end
	end

	sr64_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (data_byte),
		.last_in         (last_in),
		.mode            (mode_q),
		.scramble_enable (scr_q),
		.message_length  (len_q),
		.clear           (clear),
		.job             (fr_job),
		.job_push        (job_push)
	);

	sr64_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (fr_job),
		.pop    (job_pop),
		.dout   (head_job),
		.full   (full),
		.empty  (q_empty)
	);

	sr64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (!q_empty),
		.job_pop   (job_pop),
		.out_byte  (out_byte),
		.last_out  (last_out),
		.status    (status),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

`default_nettype wire

@@ rtl/core/sr64_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sr64_front
// Takes one input word per cycle while accept is high, tracks message state
// and builds a job describing the output words that the word causes.
// ----------------------------------------------------------------------------
module sr64_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         accept,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_in,
	input  wire logic         mode,
	input  wire logic         scramble_enable,
	input  wire logic [23:0]  message_length,
	input  wire logic         clear,
	output sr64_pkg::job_t    job,
	output logic              job_push
);
	import sr64_pkg::*;

	logic [24:0] byte_count_q, n_bc;
	logic [17:0] group_hold_q, n_hold;
	logic [1:0]  group_pos_q, n_pos;
	logic        header_sent_q, n_header_sent;
	logic        prefix_ok_q, n_prefix_ok;
	logic [23:0] dec_len_q, n_dec_len;
	logic [23:0] emitted_q, n_emitted;

	logic [7:0]  scr;
	logic [7:0]  enc_b;
	logic        done;
	logic [7:0]  dig8;
	logic [5:0]  dig;
	logic [23:0] d;
	logic [23:0] rem;
	logic [24:0] m;
	logic [25:0] tq;
	logic [25:0] dl26;
	logic        len_ok;
	logic        clr_msg;

	always_comb begin
		n_bc          = byte_count_q;
		n_hold        = group_hold_q;
		n_pos         = group_pos_q;
		n_header_sent = header_sent_q;
		n_prefix_ok   = prefix_ok_q;
		n_dec_len     = dec_len_q;
		n_emitted     = emitted_q;
		job           = '0;
		clr_msg       = 1'b0;
		scr           = scramble_enable ? SCR_MASK : 8'h00;
		enc_b         = data_byte ^ scr;
		done          = 1'b0;
		dig8          = data_byte - DIGIT_OFS;
		dig           = dig8[5:0] & DIGIT_MSK;
		d             = {group_hold_q, dig};
		rem           = dec_len_q - emitted_q;
		m             = '0;
		tq            = '0;
		dl26          = '0;
		len_ok        = 1'b0;
		if (!mode) begin
			job.hdr     = (byte_count_q == '0) && !header_sent_q;
			job.hdr_len = message_length;
			if (job.hdr) begin
				n_header_sent = 1'b1;
			end
			n_bc = byte_count_q + 25'd1;
			done = n_bc >= {1'b0, message_length};
			if (group_pos_q == 2'd2) begin
				job.grp      = 1'b1;
				job.bytes    = {group_hold_q[15:0], enc_b};
				job.grp_last = done;
				n_hold       = '0;
				n_pos        = 2'd0;
			end else begin
				n_hold = {2'b00, group_hold_q[7:0], enc_b};
				n_pos  = group_pos_q + 2'd1;
			end
			if (done) begin
				if (n_pos == 2'd1) begin
					job.grp      = 1'b1;
					job.bytes    = {n_hold[7:0], 16'h0000};
					job.grp_last = 1'b1;
				end else if (n_pos == 2'd2) begin
					job.grp      = 1'b1;
					job.bytes    = {n_hold[15:0], 8'h00};
					job.grp_last = 1'b1;
				end
				clr_msg = 1'b1;
			end
		end else begin
			if (byte_count_q < PREFIX_LEN) begin
				if (data_byte != prefix_char(byte_count_q[1:0])) begin
					n_prefix_ok = 1'b0;
				end
			end else if (group_pos_q == 2'd3) begin
				if (!header_sent_q) begin
					n_dec_len     = d;
					n_header_sent = 1'b1;
				end else if (prefix_ok_q && (emitted_q < dec_len_q)) begin
					job.nbytes = (rem >= 24'd3) ? 2'd3 : rem[1:0];
					job.bytes  = d ^ {scr, scr, scr};
					n_emitted  = emitted_q + {22'd0, job.nbytes};
				end
				n_hold = '0;
				n_pos  = 2'd0;
			end else begin
				n_hold = {group_hold_q[11:0], dig};
				n_pos  = group_pos_q + 2'd1;
			end
			if (byte_count_q != COUNT_MAX) begin
				n_bc = byte_count_q + 25'd1;
			end
			if (last_in) begin
				// count == 4*ceil(len/3) + 8, checked without a divider
				m      = n_bc - HDR_CHARS;
				tq     = {2'b00, m[24:2], 1'b0} + {3'b000, m[24:2]};
				dl26   = {2'b00, n_dec_len};
				len_ok = (n_bc >= HDR_CHARS) && (m[1:0] == 2'b00) &&
					(tq >= dl26) && (tq < dl26 + 26'd3);
				job.stat = 1'b1;
				if (n_bc < MIN_CHARS) begin
					job.stat_val = STAT_SHORT;
				end else if (!n_prefix_ok) begin
					job.stat_val = STAT_PREFIX;
				end else if (!len_ok) begin
					job.stat_val = STAT_LEN;
				end else begin
					job.stat_val = STAT_OK;
				end
				clr_msg = 1'b1;
			end
		end
		if (clr_msg) begin
			n_bc          = '0;
			n_hold        = '0;
			n_pos         = 2'd0;
			n_header_sent = 1'b0;
			n_prefix_ok   = 1'b1;
			n_dec_len     = '0;
			n_emitted     = '0;
		end
		job_push = accept && (job.hdr || job.grp || (job.nbytes != 2'd0) || job.stat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			group_hold_q  <= '0;
			group_pos_q   <= 2'd0;
			header_sent_q <= 1'b0;
			prefix_ok_q   <= 1'b1;
			dec_len_q     <= '0;
			emitted_q     <= '0;
		end else if (clear) begin
			byte_count_q  <= '0;
			group_hold_q  <= '0;
			group_pos_q   <= 2'd0;
			header_sent_q <= 1'b0;
			prefix_ok_q   <= 1'b1;
			dec_len_q     <= '0;
			emitted_q     <= '0;
		end else if (accept) begin
			byte_count_q  <= n_bc;
			group_hold_q  <= n_hold;
			group_pos_q   <= n_pos;
			header_sent_q <= n_header_sent;
			prefix_ok_q   <= n_prefix_ok;
			dec_len_q     <= n_dec_len;
			emitted_q     <= n_emitted;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sr64_job_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sr64_job_fifo
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module sr64_job_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire sr64_pkg::job_t  din,
	input  wire logic            pop,
	output sr64_pkg::job_t       dout,
	output logic                 full,
	output logic                 empty
);
	import sr64_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign dout   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sr64_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sr64_back
// Expands queued jobs into output words, one per cycle, into an output
// register that holds while the consumer stalls.
// ----------------------------------------------------------------------------
module sr64_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sr64_pkg::job_t  job,
	input  wire logic            job_valid,
	output logic                 job_pop,
	output logic [7:0]           out_byte,
	output logic                 last_out,
	output logic [1:0]           status,
	output logic                 empty,
	input  wire logic            pop
);
	import sr64_pkg::*;

	bk_state_t       st_q, n_st;
	logic [2:0]      cnt_q, n_cnt;
	logic [7:0]      ob_q;
	logic            lo_q;
	logic [1:0]      sv_q;
	logic            vld_q;

	logic            adv;
	logic            emit;
	logic            fin;
	logic [7:0]      e_byte;
	logic            e_last;
	logic [1:0]      e_stat;
	logic [7:0][5:0] hdr_dig;
	logic [3:0][5:0] grp_dig;
	logic [2:0][7:0] raw_b;

	function automatic bk_state_t next_phase(input job_t j, input bk_state_t cur);
		logic      h;
		logic      g;
		logic      r;
		logic      s;
		bk_state_t nx;
		h = j.hdr && (cur == BK_IDLE);
		g = j.grp && ((cur == BK_IDLE) || (cur == BK_HDR));
		r = (j.nbytes != 2'd0) && (cur != BK_RAW) && (cur != BK_STAT);
		s = j.stat && (cur != BK_STAT);
		if (h) begin
			nx = BK_HDR;
		end else if (g) begin
			nx = BK_GRP;
		end else if (r) begin
			nx = BK_RAW;
		end else if (s) begin
			nx = BK_STAT;
		end else begin
			nx = BK_IDLE;
		end
		return nx;
	endfunction

	assign adv      = !vld_q || pop;
	assign hdr_dig  = {HDR_B0, HDR_B1, HDR_B2, job.hdr_len};
	assign grp_dig  = job.bytes;
	assign raw_b    = job.bytes;
	assign out_byte = ob_q;
	assign last_out = lo_q;
	assign status   = sv_q;
	assign empty    = !vld_q;

	always_comb begin
		n_st    = st_q;
		n_cnt   = cnt_q;
		emit    = 1'b0;
		fin     = 1'b0;
		e_byte  = 8'h00;
		e_last  = 1'b0;
		e_stat  = STAT_OK;
		job_pop = 1'b0;
		case (st_q)
			BK_IDLE: begin
				if (job_valid) begin
					n_st  = next_phase(job, BK_IDLE);
					n_cnt = 3'd0;
				end
			end
			BK_HDR: begin
				emit   = 1'b1;
				e_byte = digit_char(hdr_dig[3'd7 - cnt_q]);
				fin    = (cnt_q == 3'd7);
			end
			BK_GRP: begin
				emit   = 1'b1;
				e_byte = digit_char(grp_dig[2'd3 - cnt_q[1:0]]);
				fin    = (cnt_q[1:0] == 2'd3);
				e_last = job.grp_last && fin;
			end
			BK_RAW: begin
				emit   = 1'b1;
				e_byte = raw_b[2'd2 - cnt_q[1:0]];
				fin    = (cnt_q[1:0] == job.nbytes - 2'd1);
			end
			BK_STAT: begin
				emit   = 1'b1;
				e_last = 1'b1;
				e_stat = job.stat_val;
				fin    = 1'b1;
			end
			default: begin
				n_st = BK_IDLE;
			end
		endcase
		if (emit && adv) begin
			n_cnt = cnt_q + 3'd1;
			if (fin) begin
				n_st  = next_phase(job, st_q);
				n_cnt = 3'd0;
				if (n_st == BK_IDLE) begin
					job_pop = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= BK_IDLE;
			cnt_q <= 3'd0;
			vld_q <= 1'b0;
		end else begin
			st_q  <= n_st;
			cnt_q <= n_cnt;
			if (adv) begin
				vld_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && adv) begin
			ob_q <= e_byte;
			lo_q <= e_last;
			sv_q <= e_stat;
		end
	end

endmodule

`default_nettype wire
